// ===== sv/pid_pkg.sv =====
// Shared types, widths, register codes and arithmetic helpers of the PID controller.
package pid_pkg;

    // Datapath widths.
    localparam int DATA_W = 32;
    localparam int FRAC_W = 16;
    localparam int LIM_W  = DATA_W - 1;
    localparam int ERR_W  = DATA_W + 1;
    localparam int WIDE_W = DATA_W + 2;
    localparam int PROD_W = 2 * DATA_W + 2;
    localparam int DPROD_W = DATA_W + ERR_W;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN_DT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_LIMIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ERROR_LIMIT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT   = 3'd7;

    // Error queue geometry.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [LIM_W-1:0]         lim_t;

    // Input request.
    typedef struct packed {
        data_t setpoint;
        data_t measured;
        logic  clear_state;
    } sample_t;

    // Result request.
    typedef struct packed {
        data_t drive;
        logic  drive_clamped;
    } result_t;

    // Configuration registers.
    typedef struct packed {
        data_t prop_gain;
        data_t integ_gain_dt;
        data_t deriv_gain_per_dt;
        lim_t  target_limit;
        lim_t  deadband_width;
        lim_t  error_limit;
        lim_t  integ_limit;
        lim_t  drive_limit;
    } cfg_t;

    // Conditioned error handed from the front end to the back end.
    typedef struct packed {
        logic  clr;
        data_t err;
    } q_item_t;

    typedef struct packed {
        logic  hit;
        data_t value;
    } clamp_t;

    // Symmetric clamp of a wide signed value to +-lim.
    function automatic clamp_t clamp_sym(input logic signed [WIDE_W-1:0] x, input lim_t lim);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        clamp_t r;
        hi = $signed({{(WIDE_W-LIM_W){1'b0}}, lim});
        lo = -hi;
        if (x > hi)
        begin
            r.hit   = 1'b1;
            r.value = hi[DATA_W-1:0];
        end
        else if (x < lo)
        begin
            r.hit   = 1'b1;
            r.value = lo[DATA_W-1:0];
        end
        else
        begin
            r.hit   = 1'b0;
            r.value = x[DATA_W-1:0];
        end
        return r;
    endfunction

    // Round a fixed-point product to nearest, ties away from zero, then saturate.
    function automatic data_t round_sat(input logic signed [PROD_W-1:0] prod);
        logic signed [PROD_W-1:0] half;
        logic signed [PROD_W-1:0] sum;
        logic signed [PROD_W-1:0] q;
        logic signed [PROD_W-1:0] dmax;
        logic signed [PROD_W-1:0] dmin;
        data_t r;
        half = '0;
        half[FRAC_W-1] = 1'b1;
        if (prod[PROD_W-1])
        begin
            half = half - PROD_W'(1);
        end
        sum  = prod + half;
        q    = sum >>> FRAC_W;
        dmax = $signed({{(PROD_W-LIM_W){1'b0}}, {LIM_W{1'b1}}});
        dmin = -dmax - PROD_W'(1);
        if (q > dmax)
        begin
            r = dmax[DATA_W-1:0];
        end
        else if (q < dmin)
        begin
            r = dmin[DATA_W-1:0];
        end
        else
        begin
            r = q[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== sv/pid_front.sv =====
// Front end: accepts sample requests and conditions the error (target clamp, deadband, clamp).
module pid_front
    import pid_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    sample_valid,
    output logic    sample_stall,
    input  sample_t sample,
    input  logic    q_full,
    output logic    push,
    output q_item_t push_item
);

    logic                    v1_reg;
    logic                    clr1_reg;
    logic signed [ERR_W-1:0] err1_reg;
    logic                    v2_reg;
    logic                    clr2_reg;
    logic signed [ERR_W-1:0] err2_reg;

    logic                    adv1;
    logic                    adv2;
    clamp_t                  tgt;
    logic signed [ERR_W-1:0] err1_next;
    logic signed [ERR_W-1:0] db;
    logic signed [ERR_W-1:0] err2_next;
    clamp_t                  err_clamp;

    // Stage flow: each stage moves when empty or when its content moves on.
    assign adv2         = !v2_reg || !q_full;
    assign adv1         = !v1_reg || adv2;
    assign sample_stall = !adv1;

    // First stage: clamp the target and form the raw error.
    always_comb
    begin
        tgt       = clamp_sym(WIDE_W'(sample.setpoint), cfg.target_limit);
        err1_next = ERR_W'(tgt.value) - ERR_W'(sample.measured);
    end

    // Second stage: remove the deadband toward zero.
    always_comb
    begin
        db = $signed({{(ERR_W-LIM_W){1'b0}}, cfg.deadband_width});
        if (err1_reg > db)
        begin
            err2_next = err1_reg - db;
        end
        else if (err1_reg < -db)
        begin
            err2_next = err1_reg + db;
        end
        else
        begin
            err2_next = '0;
        end
    end

    // Error clamp on the way into the queue.
    always_comb
    begin
        err_clamp      = clamp_sym(WIDE_W'(err2_reg), cfg.error_limit);
        push           = v2_reg && !q_full;
        push_item.clr  = clr2_reg;
        push_item.err  = err_clamp.value;
    end

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= sample_valid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            clr1_reg <= sample.clear_state;
            err1_reg <= err1_next;
        end
        if (adv2)
        begin
            clr2_reg <= clr1_reg;
            err2_reg <= err2_next;
        end
    end

endmodule

// ===== sv/pid_queue.sv =====
// Two-entry queue that decouples the error front end from the control back end.
module pid_queue
    import pid_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  q_item_t push_item,
    output logic    full,
    input  logic    pop,
    output logic    q_valid,
    output q_item_t q_item
);

    q_item_t              mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_CNT_W-1:0]   count_reg;
    logic [Q_CNT_W-1:0]   count_next;

    assign full    = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = mem_reg[rd_ptr_reg];

    // Occupancy follows pushes and pops.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + Q_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - Q_CNT_W'(1);
        end
    end

    // Pointers and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            end
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== sv/pid_back.sv =====
// Back end: derivative difference, gain multiplies, integral update, sum and drive clamp.
module pid_back
    import pid_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    q_valid,
    input  q_item_t q_item,
    output logic    pop,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    // Stage valid bits.
    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic v4_reg;
    logic v5_reg;

    // Controller state.
    data_t integ_reg;
    data_t prior_reg;
    logic  prior_valid_reg;

    // Stage 1: error and its change.
    logic                    clr1_reg;
    data_t                   err1_reg;
    logic signed [ERR_W-1:0] derr1_reg;
    logic                    dv1_reg;

    // Stage 2: raw products.
    logic                        clr2_reg;
    logic                        dv2_reg;
    logic signed [2*DATA_W-1:0]  pp2_reg;
    logic signed [2*DATA_W-1:0]  pi2_reg;
    logic signed [DPROD_W-1:0]   pd2_reg;

    // Stage 3: rounded terms.
    logic  clr3_reg;
    data_t p3_reg;
    data_t ip3_reg;
    data_t d3_reg;

    // Stage 4: proportional plus derivative; the integral sits in integ_reg.
    logic                    clr4_reg;
    logic signed [ERR_W-1:0] pd4_reg;

    result_t result_reg;

    logic adv1;
    logic adv2;
    logic adv3;
    logic adv4;
    logic adv5;

    logic signed [ERR_W-1:0]     derr_next;
    logic signed [2*DATA_W-1:0]  pp_next;
    logic signed [2*DATA_W-1:0]  pi_next;
    logic signed [DPROD_W-1:0]   pd_next;
    data_t                       d_next;
    clamp_t                      integ_clamp;
    data_t                       integ_next;
    clamp_t                      drive_clamp;
    result_t                     result_next;

    // Pipeline flow toward the result register.
    assign adv5         = !v5_reg || !result_stall;
    assign adv4         = !v4_reg || adv5;
    assign adv3         = !v3_reg || adv4;
    assign adv2         = !v2_reg || adv3;
    assign adv1         = !v1_reg || adv2;
    assign pop          = q_valid && adv1;
    assign result_valid = v5_reg;
    assign result       = result_reg;

    // Change in error since the previous sample.
    assign derr_next = ERR_W'(q_item.err) - ERR_W'(prior_reg);

    // Gain multiplies.
    always_comb
    begin
        pp_next = cfg.prop_gain * err1_reg;
        pi_next = cfg.integ_gain_dt * err1_reg;
        pd_next = cfg.deriv_gain_per_dt * derr1_reg;
    end

    // Derivative term is zero on the first sample after reset or clear.
    assign d_next = dv2_reg ? round_sat(PROD_W'(pd2_reg)) : '0;

    // Integral accumulation with its own clamp.
    always_comb
    begin
        integ_clamp = clamp_sym(WIDE_W'(integ_reg) + WIDE_W'(ip3_reg), cfg.integ_limit);
        if (clr3_reg || (cfg.integ_gain_dt == '0))
        begin
            integ_next = '0;
        end
        else
        begin
            integ_next = integ_clamp.value;
        end
    end

    // Final sum and drive clamp; a clear request yields zero.
    always_comb
    begin
        drive_clamp = clamp_sym(WIDE_W'(pd4_reg) + WIDE_W'(integ_reg), cfg.drive_limit);
        if (clr4_reg)
        begin
            result_next.drive         = '0;
            result_next.drive_clamped = 1'b0;
        end
        else
        begin
            result_next.drive         = drive_clamp.value;
            result_next.drive_clamped = drive_clamp.hit;
        end
    end

    // Valid bits and controller state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg          <= 1'b0;
            v2_reg          <= 1'b0;
            v3_reg          <= 1'b0;
            v4_reg          <= 1'b0;
            v5_reg          <= 1'b0;
            integ_reg       <= '0;
            prior_reg       <= '0;
            prior_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= q_valid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
            if (adv4)
            begin
                v4_reg <= v3_reg;
            end
            if (adv5)
            begin
                v5_reg <= v4_reg;
            end
            if (pop)
            begin
                if (q_item.clr)
                begin
                    prior_reg       <= '0;
                    prior_valid_reg <= 1'b0;
                end
                else
                begin
                    prior_reg       <= q_item.err;
                    prior_valid_reg <= 1'b1;
                end
            end
            if (v3_reg && adv4)
            begin
                integ_reg <= integ_next;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            clr1_reg  <= q_item.clr;
            err1_reg  <= q_item.err;
            derr1_reg <= derr_next;
            dv1_reg   <= prior_valid_reg;
        end
        if (adv2)
        begin
            clr2_reg <= clr1_reg;
            dv2_reg  <= dv1_reg;
            pp2_reg  <= pp_next;
            pi2_reg  <= pi_next;
            pd2_reg  <= pd_next;
        end
        if (adv3)
        begin
            clr3_reg <= clr2_reg;
            p3_reg   <= round_sat(PROD_W'(pp2_reg));
            ip3_reg  <= round_sat(PROD_W'(pi2_reg));
            d3_reg   <= d_next;
        end
        if (adv4)
        begin
            clr4_reg <= clr3_reg;
            pd4_reg  <= ERR_W'(p3_reg) + ERR_W'(d3_reg);
        end
        if (adv5)
        begin
            result_reg <= result_next;
        end
    end

endmodule

// ===== sv/pid_controller_deadband_clamp_core.sv =====
// Top level of the PID controller with deadband, symmetric clamps and anti-windup.
// The block takes one sample request per clock while sample_stall is low and gives one
// result request per sample, in order. A sample passes two front-end stages (target clamp
// and error, then deadband and error clamp), a two-entry queue and five back-end stages
// (error difference, gain multiplies, rounding, integral update, sum and drive clamp). The
// throughput of one sample per cycle when nothing stalls is set by the integral
// accumulator, a single add and clamp that feeds back into its own register. A sample with
// clear_state set zeroes the integral and the stored error and yields a zero drive.
// Configuration registers are written through cfg_write, cfg_index and cfg_data; the user
// must write them only while no sample is in flight, which the block does not enforce.
// Limits are magnitudes and the gains are signed Q16.16 values.
module pid_controller_deadband_clamp_core
    import pid_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  data_t                cfg_data,
    input  logic                 sample_valid,
    output logic                 sample_stall,
    input  sample_t              sample,
    output logic                 result_valid,
    input  logic                 result_stall,
    output result_t              result
);

    cfg_t    cfg_reg;
    logic    q_full;
    logic    push;
    q_item_t push_item;
    logic    pop;
    logic    q_valid;
    q_item_t q_item;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain         <= '0;
            cfg_reg.integ_gain_dt     <= '0;
            cfg_reg.deriv_gain_per_dt <= '0;
            cfg_reg.target_limit      <= '1;
            cfg_reg.deadband_width    <= '0;
            cfg_reg.error_limit       <= '1;
            cfg_reg.integ_limit       <= '1;
            cfg_reg.drive_limit       <= '1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_PROP_GAIN:     cfg_reg.prop_gain         <= cfg_data;
                REG_INTEG_GAIN_DT: cfg_reg.integ_gain_dt     <= cfg_data;
                REG_DERIV_GAIN:    cfg_reg.deriv_gain_per_dt <= cfg_data;
                REG_TARGET_LIMIT:  cfg_reg.target_limit      <= cfg_data[LIM_W-1:0];
                REG_DEADBAND:      cfg_reg.deadband_width    <= cfg_data[LIM_W-1:0];
                REG_ERROR_LIMIT:   cfg_reg.error_limit       <= cfg_data[LIM_W-1:0];
                REG_INTEG_LIMIT:   cfg_reg.integ_limit       <= cfg_data[LIM_W-1:0];
                REG_DRIVE_LIMIT:   cfg_reg.drive_limit       <= cfg_data[LIM_W-1:0];
                default:           cfg_reg                   <= cfg_reg;
            endcase
        end
    end

    // Error conditioning.
    pid_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .q_full       (q_full),
        .push         (push),
        .push_item    (push_item)
    );

    // Decoupling queue.
    pid_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    // Control law.
    pid_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
